// ===== rtl/core/indexed_list_store_core_macros.svh =====
// ----------------------------------------------------------------------------
// indexed_list_store_core_macros.svh
// Assertion macros used by the list store controller (ils_ctrl).
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list store check failed");

// next-cycle implication, disabled during reset
`define ILS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list store check failed");

`endif

// ===== rtl/core/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Operation and status codes, field widths and defaults for the list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;
  localparam int FILL_W = 9;

  localparam int CAPACITY_DEF = 256;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

endpackage

// ===== rtl/core/ils_mem.sv =====
// ----------------------------------------------------------------------------
// ils_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ils_mem #(
  parameter int DEPTH = ils_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(ils_pkg::CAPACITY_DEF),
  parameter int DW    = ils_pkg::WORD_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer: fill count, pad and shift walks over the entry memory,
// result register toward the output channel.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_macros.svh"

module ils_ctrl #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(ils_pkg::CAPACITY_DEF)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ils_pkg::OP_W-1:0]   in_op,
  input  logic [ils_pkg::POS_W-1:0]  in_pos,
  input  logic [ils_pkg::WORD_W-1:0] in_word,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ils_pkg::ST_W-1:0]   out_status,
  output logic [ils_pkg::WORD_W-1:0] out_word,
  output logic [ils_pkg::FILL_W-1:0] out_fill,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ils_pkg::WORD_W-1:0] mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  logic [ils_pkg::WORD_W-1:0] mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + ils_pkg::POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_GET   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pend_addr_r, pend_addr_nxt;
  logic [ils_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [ils_pkg::WORD_W-1:0]  word_r, word_nxt;
  logic [ils_pkg::ST_W-1:0]    res_status_r, res_status_nxt;
  logic [ils_pkg::WORD_W-1:0]  res_word_r, res_word_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ils_pkg::ST_W-1:0]    out_status_r, out_status_nxt;
  logic [ils_pkg::WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [ils_pkg::FILL_W-1:0]  out_fill_r, out_fill_nxt;

  logic [XW-1:0]   pos_x, posr_x, cnt_x, cap_x, waddr_x;
  logic [AW+7:0]   in_pos_a;
  logic [CW+8:0]   fill_x;
  logic            issue;
  logic            accept;

  assign pos_x    = XW'(in_pos);
  assign posr_x   = XW'(pos_r);
  assign cnt_x    = XW'(count_r);
  assign cap_x    = XW'(CAPACITY);
  assign waddr_x  = XW'(mem_waddr);
  assign in_pos_a = (AW + 8)'(in_pos);
  assign fill_x   = (CW + 9)'(count_r);
  assign issue    = (idx_r < count_r);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    res_status_nxt = res_status_r;
    res_word_nxt   = res_word_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_fill_nxt   = out_fill_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = '0;
    mem_raddr      = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        mem_raddr = in_pos_a[AW-1:0];
        if (accept) begin
          pos_nxt        = in_pos;
          word_nxt       = in_word;
          res_status_nxt = ils_pkg::ST_DONE;
          res_word_nxt   = '0;
          state_nxt      = S_DONE;
          case (in_op)
            ils_pkg::OP_APPEND: begin
              if (cnt_x < cap_x) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_word;
                count_nxt = CW'(count_r + 1'b1);
              end else begin
                res_status_nxt = ils_pkg::ST_FULL;
              end
            end
            ils_pkg::OP_SET: begin
              if (pos_x >= cap_x) begin
                res_status_nxt = ils_pkg::ST_FULL;
              end else if (pos_x < cnt_x) begin
                mem_we    = 1'b1;
                mem_waddr = in_pos_a[AW-1:0];
                mem_wdata = in_word;
              end else begin
                state_nxt = S_PAD;
              end
            end
            ils_pkg::OP_GET: begin
              if (pos_x < cnt_x) begin
                state_nxt = S_GET;
              end else begin
                res_status_nxt = ils_pkg::ST_BAD_INDEX;
              end
            end
            ils_pkg::OP_REMOVE: begin
              if (pos_x < cnt_x) begin
                idx_nxt   = CW'(pos_x + XW'(1));
                state_nxt = S_SHIFT;
              end else begin
                res_status_nxt = ils_pkg::ST_BAD_INDEX;
              end
            end
            ils_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD: begin
        // zero-fill up to the target entry, which takes the new word
        mem_we    = 1'b1;
        mem_waddr = count_r[AW-1:0];
        mem_wdata = (cnt_x == posr_x) ? word_r : '0;
        count_nxt = CW'(count_r + 1'b1);
        if (cnt_x == posr_x) begin
          state_nxt = S_DONE;
        end
      end
      S_GET: begin
        res_word_nxt = mem_rdata;
        state_nxt    = S_DONE;
      end
      S_SHIFT: begin
        // read entry i+1, then write it to entry i once the read data is registered
        mem_raddr     = idx_r[AW-1:0];
        pend_nxt      = issue;
        pend_addr_nxt = AW'(idx_r - 1'b1);
        if (issue) begin
          idx_nxt = CW'(idx_r + 1'b1);
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (!issue && !pend_r) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_word_nxt   = res_word_r;
          out_fill_nxt   = fill_x[ils_pkg::FILL_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_word_r   <= res_word_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_word   = out_word_r;
  assign out_fill   = out_fill_r;

  `ILS_ASSERT_IMPL(a_count_bound, 1'b1, cnt_x <= cap_x)
  `ILS_ASSERT_IMPL(a_waddr_bound, mem_we, waddr_x < cap_x)
  `ILS_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE)
  `ILS_ASSERT_NEXT(a_get_done, state_r == S_GET, state_r == S_DONE)
  `ILS_ASSERT_IMPL(a_shift_pend, pend_r, state_r == S_SHIFT)

endmodule

// ===== rtl/core/indexed_list_store_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Bounded ordered list of signed 32-bit words held in one entry memory.
// ----------------------------------------------------------------------------
// One request at a time: in_tready is high only in the idle state. Append,
// clear, in-range set, unused opcodes and error cases go straight to the
// result state; get first reads the entry memory. Set past the end walks the
// padded entries (position - count + 1); remove walks the shift over the
// entries past the position. in_tready returns once the result loads into the
// output register, which waits while an earlier result is not yet taken.
// Reset clears the fill count and handshake state; entries stay unreset.
module indexed_list_store_core #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[7:0], word_in[39:8]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // word_out[31:0], fill_count[40:32], zero[47:41]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int AW = $clog2(CAPACITY);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ils_pkg::WORD_W-1:0]  mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [ils_pkg::WORD_W-1:0]  mem_rdata;
  logic [ils_pkg::WORD_W-1:0]  out_word;
  logic [ils_pkg::FILL_W-1:0]  out_fill;

  ils_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_pos     (in_tdata[7:0]),
    .in_word    (in_tdata[39:8]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_word   (out_word),
    .out_fill   (out_fill),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ils_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (ils_pkg::WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = {7'b0, out_fill, out_word};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_list_store_core. A behavioral copy of the
// list tracks every accepted request and queues the reply it should produce.
// Replies are checked in order. Directed cases cover empty and full lists,
// padding, shifts and the unused opcodes. Random traffic then runs under
// three idle mixes, with one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAPACITY    = ils_pkg::CAPACITY_DEF;
  localparam int AW          = $clog2(CAPACITY);
  localparam int PW          = ils_pkg::POS_W;
  localparam int OW          = ils_pkg::OP_W;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = CAPACITY + 40;
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic [ils_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [ils_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [ils_pkg::ST_W-1:0]   status;
    logic [ils_pkg::WORD_W-1:0] word;
    logic [ils_pkg::FILL_W-1:0] fill;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // position[7:0], word_in[39:8]
  logic [2:0]  in_tuser = '0;   // operation[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // word_out[31:0], fill_count[40:32], zero[47:41]
  logic [1:0]  out_tuser;       // status[1:0]

  logic [ils_pkg::WORD_W-1:0] list_mem [CAPACITY];
  int unsigned                list_len = 0;
  list_reply_t                pending_replies [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int errors        = 0;
  int replies_seen  = 0;
  int full_seen     = 0;
  int bad_idx_seen  = 0;
  int unused_seen   = 0;
  int op_seen [8]   = '{default: 0};

  indexed_list_store_core #(.CAPACITY(CAPACITY)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, pending_replies.size());
      $display("** indexed_list_store_core: FAILED **");
      $finish;
    end
  end

  // list behavior, applied in transfer order
  function automatic list_reply_t apply_list_request(
      input logic [ils_pkg::OP_W-1:0]   op,
      input logic [ils_pkg::POS_W-1:0]  pos,
      input logic [ils_pkg::WORD_W-1:0] word);
    list_reply_t r;
    int unsigned i;
    r = '{status: ils_pkg::ST_DONE, word: '0, fill: '0};
    op_seen[op]++;
    case (op)
      ils_pkg::OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_mem[AW'(list_len)] = word;
          list_len++;
        end else begin
          r.status = ils_pkg::ST_FULL;
        end
      end
      ils_pkg::OP_SET: begin
        if (32'(pos) >= CAPACITY) begin
          r.status = ils_pkg::ST_FULL;
        end else begin
          while (list_len <= 32'(pos)) begin
            list_mem[AW'(list_len)] = '0;
            list_len++;
          end
          list_mem[AW'(pos)] = word;
        end
      end
      ils_pkg::OP_GET: begin
        if (32'(pos) < list_len) r.word = list_mem[AW'(pos)];
        else r.status = ils_pkg::ST_BAD_INDEX;
      end
      ils_pkg::OP_REMOVE: begin
        if (32'(pos) < list_len) begin
          for (i = 32'(pos); i + 1 < list_len; i++) begin
            list_mem[AW'(i)] = list_mem[AW'(i + 1)];
          end
          list_len--;
        end else begin
          r.status = ils_pkg::ST_BAD_INDEX;
        end
      end
      ils_pkg::OP_CLEAR: begin
        for (i = 0; i < list_len; i++) list_mem[AW'(i)] = '0;
        list_len = 0;
      end
      default: unused_seen++;
    endcase
    r.fill = list_len[ils_pkg::FILL_W-1:0];
    return r;
  endfunction

  // called and returns at a falling edge; valid stays up for the next call
  task automatic send_request(input logic [ils_pkg::OP_W-1:0]   op,
                              input logic [ils_pkg::POS_W-1:0]  pos,
                              input logic [ils_pkg::WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {word, pos};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(apply_list_request(op, pos, word));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    list_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d word=%h fill=%0d",
                 $time, out_tuser, out_tdata[31:0], out_tdata[40:32]);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (want.status == ils_pkg::ST_FULL) full_seen++;
        if (want.status == ils_pkg::ST_BAD_INDEX) bad_idx_seen++;
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] !== want.word) begin
          $display("%0t: word_out expected %h actual %h", $time, want.word,
                   out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[40:32] !== want.fill) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, want.fill,
                   out_tdata[40:32]);
          errors++;
        end
        if (out_tdata[47:41] !== '0) begin
          $display("%0t: pad bits expected 0 actual %h", $time, out_tdata[47:41]);
          errors++;
        end
      end
    end
  end

  function automatic logic [ils_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ils_pkg::POS_W-1:0] pick_position(input int wide_pct);
    int unsigned top;
    top = (list_len + 3 > 255) ? 255 : list_len + 3;
    if ($urandom_range(99) < wide_pct) return PW'($urandom_range(255));
    return PW'($urandom_range(top, 0));
  endfunction

  task automatic test_directed();
    send_request(ils_pkg::OP_GET, 8'd0, '0);
    send_request(ils_pkg::OP_REMOVE, 8'd0, '0);
    send_request(ils_pkg::OP_CLEAR, 8'd0, '0);
    send_request(ils_pkg::OP_APPEND, 8'd0, 32'h7fff_ffff);
    send_request(ils_pkg::OP_APPEND, 8'd0, 32'h8000_0000);
    send_request(ils_pkg::OP_APPEND, 8'd0, 32'hffff_ffff);
    send_request(ils_pkg::OP_GET, 8'd1, '0);
    send_request(ils_pkg::OP_GET, 8'd3, '0);
    send_request(ils_pkg::OP_SET, 8'd1, 32'h0000_0000);
    send_request(ils_pkg::OP_SET, 8'd5, 32'h1234_5678);
    send_request(ils_pkg::OP_GET, 8'd4, '0);
    send_request(ils_pkg::OP_REMOVE, 8'd0, '0);
    send_request(ils_pkg::OP_GET, 8'd0, '0);
    send_request(ils_pkg::OP_REMOVE, 8'd4, '0);
    send_request(OP_UNUSED_FIRST, 8'hff, 32'hdead_beef);
    send_request(OP_UNUSED_LAST, 8'h00, 32'h0bad_f00d);
    send_request(ils_pkg::OP_CLEAR, 8'd0, '0);
    send_request(ils_pkg::OP_GET, 8'd0, '0);
  endtask

  // pad from empty to a full list, then exercise the full boundary
  task automatic test_full_list();
    send_request(ils_pkg::OP_SET, 8'd255, 32'ha5a5_a5a5);
    send_request(ils_pkg::OP_APPEND, 8'd0, 32'h1111_1111);
    send_request(ils_pkg::OP_GET, 8'd255, '0);
    send_request(ils_pkg::OP_REMOVE, 8'd0, '0);
    send_request(ils_pkg::OP_GET, 8'd254, '0);
    send_request(ils_pkg::OP_APPEND, 8'd0, 32'h0000_0001);
    send_request(ils_pkg::OP_REMOVE, 8'd255, '0);
    send_request(ils_pkg::OP_CLEAR, 8'd0, '0);
  endtask

  task automatic test_random(input int count);
    int k;
    int r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 32) begin
        send_request(ils_pkg::OP_APPEND, PW'($urandom_range(255)), pick_word());
      end else if (r < 50) begin
        send_request(ils_pkg::OP_SET, pick_position(10), pick_word());
      end else if (r < 72) begin
        send_request(ils_pkg::OP_GET, pick_position(15), $urandom);
      end else if (r < 89) begin
        send_request(ils_pkg::OP_REMOVE, pick_position(15), $urandom);
      end else if (r < 93) begin
        send_request(ils_pkg::OP_CLEAR, PW'($urandom_range(255)), $urandom);
      end else if (r < 96) begin
        send_request(OW'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                     PW'($urandom_range(255)), $urandom);
      end else begin
        send_request(ils_pkg::OP_APPEND, 8'd0, pick_word());
      end
    end
  endtask

  // long output stall with input still offered, then a full drain
  task automatic test_backpressure();
    int k;
    wait_drained();
    hold_requests <= hold_requests + 1;
    for (k = 0; k < 6; k++) send_request(ils_pkg::OP_APPEND, 8'd0, pick_word());
    send_request(ils_pkg::OP_REMOVE, 8'd0, '0);
    send_request(ils_pkg::OP_GET, 8'd0, '0);
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct <= 64;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_list();
    test_random(480);
    test_backpressure();

    send_idle_pct = 64;
    recv_idle_pct <= 22;
    test_random(485);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_random(485);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("requests: append %0d, set %0d, get %0d, remove %0d, clear %0d, unused %0d",
             op_seen[ils_pkg::OP_APPEND], op_seen[ils_pkg::OP_SET],
             op_seen[ils_pkg::OP_GET], op_seen[ils_pkg::OP_REMOVE],
             op_seen[ils_pkg::OP_CLEAR], unused_seen);
    $display("replies checked %0d (list full %0d, bad index %0d), errors %0d",
             replies_seen, full_seen, bad_idx_seen, errors);
    if (errors == 0) begin
      $display("** indexed_list_store_core: PASSED **");
    end else begin
      $display("** indexed_list_store_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== indexed_list_store_core.f =====
+incdir+rtl/core
rtl/core/ils_pkg.sv
rtl/core/ils_mem.sv
rtl/core/ils_ctrl.sv
rtl/core/indexed_list_store_core.sv
tb/tb.sv
